// ----- rtl/slrg_pkg.sv -----
// Package for the shuffled Lehmer generator: modulus, multiplier, clamp limit
// and the modular fold used after the 31x15 multiply.
// No dependencies.
`default_nettype none

package slrg_pkg;

   localparam int          DEF_TABLE_DEPTH = 32;
   localparam int          WORD_W          = 31;
   localparam int          FRAC_W          = 24;
   localparam int          MULT_W          = 15;
   localparam int          PROD_W          = WORD_W + MULT_W;

   localparam logic [WORD_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
   localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
   localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

   localparam logic           KIND_DRAW = 1'b0;
   localparam logic           KIND_SEED = 1'b1;

   // Reduce a product modulo 2^31-1: high part folds onto the low part,
   // then one conditional subtract (the sum stays below twice the modulus).
   function automatic logic [WORD_W-1:0] slrg_fold(input logic [PROD_W-1:0] prod);
      logic [WORD_W:0] sum;
      logic [WORD_W:0] red;
      sum = {1'b0, prod[WORD_W-1:0]} + {{(WORD_W+1-MULT_W){1'b0}}, prod[PROD_W-1:WORD_W]};
      red = sum - {1'b0, LCG_MOD};
      if (sum >= {1'b0, LCG_MOD}) begin
         return red[WORD_W-1:0];
      end
      return sum[WORD_W-1:0];
   endfunction

endpackage : slrg_pkg

`default_nettype wire

// ----- rtl/slrg_table.sv -----
// Shuffle table: single write port, single read port, registered read data.
// Depends on slrg_pkg for the word width.
`default_nettype none

module slrg_table #(
   parameter int TABLE_DEPTH = slrg_pkg::DEF_TABLE_DEPTH,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [slrg_pkg::WORD_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [slrg_pkg::WORD_W-1:0] rd_data_ff
);
   import slrg_pkg::*;

   logic [WORD_W-1:0] mem_ff [TABLE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered, holds when not read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule : slrg_table

`default_nettype wire

// ----- rtl/shuffled_lehmer_random_generator.sv -----
// Shuffled Lehmer generator (minimal standard multiplier 16807, modulus
// 2^31-1) with a shuffle table of TABLE_DEPTH entries. A draw goes through
// multiply and table index at the accepting edge, modular fold with the table
// read, then write back and result load, which waits while an earlier result
// is still unaccepted; the next transaction is taken once back in idle. A seed
// transaction, or the first draw after reset, first runs TABLE_DEPTH+8
// warm-up steps, each a multiply state and a fold state, then a separate
// multiply state before the draw's fold and write-back. The result register
// lets a new transaction be accepted while the previous result is still
// waiting. No clearing pass after reset.
// Depends on slrg_pkg and slrg_table.
`default_nettype none

module shuffled_lehmer_random_generator #(
   parameter int TABLE_DEPTH = slrg_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_kind,
   input  wire logic [slrg_pkg::WORD_W-1:0] req_seed_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [slrg_pkg::WORD_W-1:0] rsp_raw_value,
   output logic      [slrg_pkg::FRAC_W-1:0] rsp_uniform_fraction
);
   import slrg_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 8);
   localparam logic [WORD_W:0] TABLE_DIV =
      (WORD_W+1)'(1 + (32'(LCG_MOD) - 32'd1) / TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SMUL,
      ST_SFOLD,
      ST_DMUL,
      ST_DFOLD,
      ST_DWB
   } state_type;

   state_type          state_ff, state_in;
   logic               seeded_ff, seeded_in;
   logic [WORD_W-1:0]  x_ff, x_in;
   logic [WORD_W-1:0]  last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  raw_ff, raw_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [WORD_W-1:0]  fold_val;
   logic [ADDR_W-1:0]  idx_calc;
   logic [WORD_W-1:0]  seed_x;
   logic [WORD_W-1:0]  rd_data;
   logic [FRAC_W-1:0]  frac_calc;
   logic               req_fire;
   logic               out_free;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               rd_en;

   assign req_ready            = (state_ff == ST_IDLE);
   assign req_fire             = req_valid && req_ready;
   assign out_free             = !rsp_valid_ff || rsp_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_value        = raw_ff;
   assign rsp_uniform_fraction = frac_ff;

   assign fold_val = slrg_fold(prod_ff);

   // zero seed and the modulus itself both start from one
   assign seed_x = (req_seed_value == '0 || req_seed_value == LCG_MOD) ?
                   WORD_W'(1) : req_seed_value;

   // table index: last output divided by the bucket size, as a threshold scan
   always_comb begin
      idx_calc = '0;
      for (int k = 1; k < TABLE_DEPTH; k++) begin
         if ({1'b0, last_ff} >= (WORD_W+1)'(k) * TABLE_DIV) begin
            idx_calc = ADDR_W'(k);
         end
      end
   end

   // fraction from the table word, clamped below one
   always_comb begin
      frac_calc = rd_data[WORD_W-1:WORD_W-FRAC_W];
      if (frac_calc > FRAC_MAX) begin
         frac_calc = FRAC_MAX;
      end
   end

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      seeded_in    = seeded_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      raw_in       = raw_ff;
      frac_in      = frac_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = x_ff;
      rd_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_SEED || !seeded_ff) begin
                  x_in     = (req_kind == KIND_SEED) ? seed_x : WORD_W'(1);
                  cnt_in   = CNT_W'(TABLE_DEPTH + 7);
                  state_in = ST_SMUL;
               end else begin
                  prod_in  = PROD_W'(x_ff) * PROD_W'(LCG_MULT);
                  idx_in   = idx_calc;
                  state_in = ST_DFOLD;
               end
            end
         end
         ST_SMUL: begin
            prod_in  = PROD_W'(x_ff) * PROD_W'(LCG_MULT);
            state_in = ST_SFOLD;
         end
         ST_SFOLD: begin
            x_in    = fold_val;
            wr_addr = cnt_ff[ADDR_W-1:0];
            wr_data = fold_val;
            wr_en   = (cnt_ff < CNT_W'(TABLE_DEPTH));
            if (cnt_ff == '0) begin
               // entry 0 is the last warm-up value
               last_in   = fold_val;
               seeded_in = 1'b1;
               state_in  = ST_DMUL;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_SMUL;
            end
         end
         ST_DMUL: begin
            prod_in  = PROD_W'(x_ff) * PROD_W'(LCG_MULT);
            idx_in   = idx_calc;
            state_in = ST_DFOLD;
         end
         ST_DFOLD: begin
            x_in     = fold_val;
            rd_en    = 1'b1;
            state_in = ST_DWB;
         end
         ST_DWB: begin
            if (out_free) begin
               wr_en        = 1'b1;
               last_in      = rd_data;
               raw_in       = rd_data;
               frac_in      = frac_calc;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state and registered result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         x_ff         <= WORD_W'(1);
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         x_ff         <= x_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      frac_ff <= frac_in;
      prod_ff <= prod_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
   end

   slrg_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (idx_ff),
      .rd_data_ff (rd_data)
   );

`ifndef SYNTH
   // every delivered value comes from a seeded table and is never zero
   a_raw_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (raw_ff != '0))
      else $error("zero raw value delivered");

   // the last warm-up step marks the generator seeded
   a_seed_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SFOLD && cnt_ff == '0) |=> seeded_ff)
      else $error("seeding finished without setting seeded flag");

   // a table read never leaves the configured depth
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DFOLD) |-> (32'(idx_ff) < TABLE_DEPTH))
      else $error("table index out of range");

   // a new result only comes from the write-back step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DWB))
      else $error("result raised outside write-back");
`endif

endmodule : shuffled_lehmer_random_generator

`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for shuffled_lehmer_random_generator: drives draw and reseed
// transactions and checks every result against an in-bench minimal-standard/shuffle predictor.
// Depends on slrg_pkg and the generator RTL.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import slrg_pkg::*;

   localparam int CLK_PERIOD  = 4;
   localparam int RESET_LEN   = 10;
   localparam int DEPTH       = DEF_TABLE_DEPTH;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint unsigned MOD64   = 64'd2147483647;
   localparam longint unsigned MULT64  = 64'd16807;
   localparam longint unsigned IDX_DIV = 64'd1 + (MOD64 - 64'd1) / DEPTH;

   typedef struct packed {
      logic [WORD_W-1:0] raw;
      logic [FRAC_W-1:0] frac;
   } draw_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic [WORD_W-1:0] req_seed_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_raw_value;
   logic [FRAC_W-1:0] rsp_uniform_fraction;

   // Predictor state
   logic [WORD_W-1:0] gen_word;
   logic [WORD_W-1:0] shuffle_tbl [DEPTH];
   logic [WORD_W-1:0] last_word;
   bit                seeded;

   draw_result_type   expected_draws [$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   bit                burst_mode     = 1'b0;
   int                rsp_holdoff_cycles = 0;

   shuffled_lehmer_random_generator u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_seed_value      (req_seed_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_raw_value       (rsp_raw_value),
      .rsp_uniform_fraction(rsp_uniform_fraction)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic [WORD_W-1:0] lehmer_step(input logic [WORD_W-1:0] x);
      longint unsigned prod;
      prod = 64'(x) * MULT64;
      return WORD_W'(prod % MOD64);
   endfunction

   // Load the generator and fill the shuffle table after the warm-up steps
   task automatic predict_seed(input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] x;
      x = seed;
      if (x == '0 || 64'(x) >= MOD64) x = WORD_W'(1);
      for (int i = DEPTH + 7; i >= 0; i--) begin
         x = lehmer_step(x);
         if (i < DEPTH) shuffle_tbl[i] = x;
      end
      gen_word  = x;
      last_word = shuffle_tbl[0];
      seeded    = 1'b1;
   endtask

   task automatic predict_draw(input logic kind, input logic [WORD_W-1:0] seed,
                               output draw_result_type res);
      longint unsigned   idx;
      logic [WORD_W-1:0] shifted;
      if (kind == KIND_SEED) predict_seed(seed);
      else if (!seeded) predict_seed(WORD_W'(1));
      gen_word = lehmer_step(gen_word);
      idx = 64'(last_word) / IDX_DIV;
      if (idx >= 64'(DEPTH)) idx = 64'(DEPTH - 1);
      last_word        = shuffle_tbl[idx];
      shuffle_tbl[idx] = gen_word;
      shifted  = last_word >> 7;
      res.raw  = last_word;
      res.frac = (shifted > WORD_W'(FRAC_MAX)) ? FRAC_MAX : shifted[FRAC_W-1:0];
   endtask

   // ---------------------------------------------------------------- sender
   task automatic send_item(input logic kind, input logic [WORD_W-1:0] seed);
      int              gap;
      draw_result_type res;
      gap = burst_mode ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_seed_value <= seed;
      do @(posedge clock); while (!req_ready);
      predict_draw(kind, seed, res);
      expected_draws.push_back(res);
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver
   initial begin : result_sink
      int wait_cycles;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_holdoff_cycles > 0) begin
            wait_cycles        = rsp_holdoff_cycles;
            rsp_holdoff_cycles = 0;
         end else begin
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 3);
         end
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin : result_check
      draw_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_draws.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result expected none actual raw=%0d frac=%0d",
                     $realtime, rsp_raw_value, rsp_uniform_fraction);
         end else begin
            want = expected_draws.pop_front();
            if (rsp_raw_value !== want.raw) begin
               mismatch_count++;
               $display("%0t: raw_value expected %0d actual %0d", $realtime,
                        want.raw, rsp_raw_value);
            end
            if (rsp_uniform_fraction !== want.frac) begin
               mismatch_count++;
               $display("%0t: uniform_fraction expected %0d actual %0d", $realtime,
                        want.frac, rsp_uniform_fraction);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Draws straight out of reset must self-seed with one
   task automatic test_draw_before_seed();
      send_item(KIND_DRAW, 31'h7FFF_FFFF);
      send_item(KIND_DRAW, '0);
      send_item(KIND_DRAW, 31'h1234_5678);
      release_req();
   endtask

   // Seed extremes: zero, one, largest legal, the modulus itself, bit patterns
   task automatic test_seed_extremes();
      logic [WORD_W-1:0] seeds [6];
      seeds = '{31'd0, 31'd1, 31'd2147483646, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA};
      foreach (seeds[i]) begin
         send_item(KIND_SEED, seeds[i]);
         send_item(KIND_DRAW, ~seeds[i]);
         send_item(KIND_DRAW, seeds[i]);
      end
      release_req();
   endtask

   // Long receiver hold-off while draws keep coming, so the block stalls its input
   task automatic test_backpressure();
      burst_mode         = 1'b1;
      rsp_holdoff_cycles = 80;
      for (int i = 0; i < 16; i++) send_item(KIND_DRAW, WORD_W'($urandom()));
      burst_mode = 1'b0;
      release_req();
   endtask

   function automatic logic [WORD_W-1:0] pick_seed();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 31'd2147483646;
         3:       return WORD_W'($urandom_range(1, 1000));
         default: return WORD_W'($urandom());
      endcase
   endfunction

   // Mostly draws with occasional reseeds; bursts with no idling now and then
   task automatic test_random_mix();
      for (int n = 0; n < 620; n++) begin
         burst_mode = ((n / 40) % 4 == 3);
         if ($urandom_range(0, 99) < 8) send_item(KIND_SEED, pick_seed());
         else send_item(KIND_DRAW, WORD_W'($urandom()));
      end
      burst_mode = 1'b0;
      release_req();
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_DRAW;
      req_seed_value <= '0;
      gen_word        = WORD_W'(1);
      last_word       = '0;
      seeded          = 1'b0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_draw_before_seed();
      test_seed_extremes();
      test_backpressure();
      test_random_mix();

      while (expected_draws.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule : tb

`default_nettype wire

// ----- files.f -----
rtl/slrg_pkg.sv
rtl/slrg_table.sv
rtl/shuffled_lehmer_random_generator.sv
bench/tb.sv
